[rtl/core/vrp_pkg.sv]
// Shared constants for the voxel ray picking block and its checker.
package vrp_pkg;

	localparam int GRID_W_DEF = 32;
	localparam int GRID_H_DEF = 32;
	localparam int GRID_D_DEF = 32;

	localparam int AXES   = 3;
	localparam int CELL_W = 5;
	localparam int CODE_W = 8;
	localparam int EYE_W  = 32;
	localparam int DIR_W  = 16;
	localparam int POS_W  = 6;
	localparam int IDX_W  = 2;
	localparam int BS_W   = 8;
	localparam int LIM_W  = 6;

	localparam int FIX_W  = 49;
	localparam int TILE_W = 17;
	localparam int NUM_W  = 63;
	localparam int DEN_W  = 16;
	localparam int CNT_W  = 6;
	localparam int MA_W   = 25;
	localparam int MP_W   = 41;
	localparam int ACC_W  = 66;
	localparam int SUM_W  = 53;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
	localparam logic [IDX_W-1:0] REG_OPEN_CODE  = 2'd1;
	localparam logic [IDX_W-1:0] REG_STEP_LIMIT = 2'd2;

	localparam logic [BS_W-1:0]   BLOCK_SIZE_RST = 8'd8;
	localparam logic [CODE_W-1:0] OPEN_CODE_RST  = 8'd0;
	localparam logic [LIM_W-1:0]  STEP_LIMIT_RST = 6'd7;

	localparam logic [POS_W-1:0] POS_MISS = 6'h3F;

	localparam logic signed [FIX_W-1:0] FIX_MAX = 49'sh0_8000_0000_0000;
	localparam logic signed [FIX_W-1:0] FIX_MIN = 49'sh1_8000_0000_0000;
	localparam logic [NUM_W-1:0] QUO_LIM = 63'h0000_8000_0000_0000;

endpackage

[rtl/core/voxel_ray_pick.sv]
// Voxel ray picking over a stored 3D tile grid with one shared divider and multiplier.
//
//   Channel | Direction | Handshake            | Content
//   in      | input     | in_valid / in_ready  | one tile write or one ray query
//   cfg     | input     | cfg_valid/cfg_ready  | register index and data, always ready
//   out     | output    | out_valid/out_ready  | one pick result per query
//
// A tile write is stored in the cycle it is accepted. A query finds its start
// tile in three passes of one load step and the shared divider, then walks
// boundary crossings, each of which is up to three divider passes, the multiply
// and update steps for each axis and one tile store read.
// After reset the block clears the tile store, one entry per cycle, through all
// GRID_W*GRID_H*GRID_D entries (32768 by default); in_ready stays low meanwhile.
// A finished result waits in the output register; the next item is accepted
// while it waits, and only the end of the next query stalls on out_ready.
module voxel_ray_pick #(
	parameter int GRID_W = vrp_pkg::GRID_W_DEF,
	parameter int GRID_H = vrp_pkg::GRID_H_DEF,
	parameter int GRID_D = vrp_pkg::GRID_D_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic        [vrp_pkg::CELL_W-1:0]   cell_x,
	input  logic        [vrp_pkg::CELL_W-1:0]   cell_y,
	input  logic        [vrp_pkg::CELL_W-1:0]   cell_z,
	input  logic        [vrp_pkg::CODE_W-1:0]   cell_code,
	input  logic signed [vrp_pkg::EYE_W-1:0]    eye_x,
	input  logic signed [vrp_pkg::EYE_W-1:0]    eye_y,
	input  logic signed [vrp_pkg::EYE_W-1:0]    eye_z,
	input  logic signed [vrp_pkg::DIR_W-1:0]    dir_x,
	input  logic signed [vrp_pkg::DIR_W-1:0]    dir_y,
	input  logic signed [vrp_pkg::DIR_W-1:0]    dir_z,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [vrp_pkg::IDX_W-1:0]    cfg_index,
	input  logic        [vrp_pkg::CODE_W-1:0]   cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic signed [vrp_pkg::POS_W-1:0]    hit_x,
	output logic signed [vrp_pkg::POS_W-1:0]    hit_y,
	output logic signed [vrp_pkg::POS_W-1:0]    hit_z,
	output logic signed [vrp_pkg::POS_W-1:0]    before_x,
	output logic signed [vrp_pkg::POS_W-1:0]    before_y,
	output logic signed [vrp_pkg::POS_W-1:0]    before_z
);
	import vrp_pkg::*;

	localparam int DEPTH = GRID_W * GRID_H * GRID_D;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [14:0] {
		S_CLEAR = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_TLOAD = 15'b000000000000100,
		S_DIV   = 15'b000000000001000,
		S_STEP  = 15'b000000000010000,
		S_BND   = 15'b000000000100000,
		S_DIFF  = 15'b000000001000000,
		S_PICK  = 15'b000000010000000,
		S_MLO   = 15'b000000100000000,
		S_MHI   = 15'b000001000000000,
		S_SUM   = 15'b000010000000000,
		S_EYE   = 15'b000100000000000,
		S_CHK   = 15'b001000000000000,
		S_CMP   = 15'b010000000000000,
		S_DONE  = 15'b100000000000000
	} state_t;

	// Control state.
	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [BS_W-1:0]   bs_q;
	logic [CODE_W-1:0] open_q;
	logic [LIM_W-1:0]  lim_q;
	logic [1:0]        k_q;
	logic [LIM_W-1:0]  step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              tile_ph_q;
	logic              hit_q;
	logic              out_valid_q;

	// Datapath.
	logic signed [FIX_W-1:0]  eye_q [AXES];
	logic signed [DIR_W-1:0]  dir_q [AXES];
	logic signed [TILE_W-1:0] t_q   [AXES];
	logic signed [TILE_W-1:0] bef_q [AXES];
	logic signed [FIX_W-1:0]  amt_q [AXES];
	logic signed [FIX_W-1:0]  amt_sel_q;
	logic [DEN_W-1:0]         rem_q;
	logic [NUM_W-1:0]         numq_q;
	logic [DEN_W-1:0]         den_q;
	logic                     neg_q;
	logic signed [MP_W-1:0]   mul_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [CODE_W-1:0]        rd_q;
	logic                     hit_o_q;
	logic [POS_W-1:0]         pos_q [2*AXES];

	logic [CODE_W-1:0] mem [DEPTH];

	// Combinational signals.
	logic                     in_acc;
	logic                     slot_free;
	logic [BS_W-1:0]          bs_eff;
	logic signed [FIX_W-1:0]  eye_k;
	logic signed [DIR_W-1:0]  dir_k;
	logic signed [TILE_W-1:0] t_k;
	logic signed [TILE_W-1:0] t_bnd;
	logic [EYE_W-1:0]         eye_mag;
	logic signed [49:0]       bnd_w;
	logic signed [49:0]       diff_w;
	logic [FIX_W-1:0]         diff_mag;
	logic [DEN_W-1:0]         dir_mag;
	logic [DEN_W:0]           trial;
	logic                     ge;
	logic [DEN_W:0]           rem_n;
	logic [NUM_W-1:0]         q_fin;
	logic                     div_last;
	logic signed [TILE_W-1:0] t_res;
	logic signed [FIX_W-1:0]  q_sat;
	logic signed [FIX_W-1:0]  amt_res;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [DIR_W-1:0]  mul_b;
	logic signed [MP_W-1:0]   mul_p;
	logic signed [51:0]       move_w;
	logic signed [38:0]       move2_w;
	logic signed [SUM_W-1:0]  eye_sum;
	logic signed [FIX_W-1:0]  eye_new;
	logic [AXES-1:0]          nz;
	logic                     ax0, ax1, ax2;
	logic [1:0]               ax_w;
	logic                     pick_none;
	logic                     t_in_grid;
	logic                     w_in_grid;
	logic [AW-1:0]            raddr;
	logic [AW-1:0]            waddr;
	logic                     mem_we;
	logic [AW-1:0]            mem_wa;
	logic [CODE_W-1:0]        mem_wd;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign bs_eff    = (bs_q == '0) ? BS_W'(1) : bs_q;

	assign eye_k = eye_q[k_q];
	assign dir_k = dir_q[k_q];
	assign t_k   = t_q[k_q];
	assign t_bnd = t_k + ((dir_k > 0) ? TILE_W'(1) : TILE_W'(0));

	assign eye_mag  = eye_k[FIX_W-1] ? EYE_W'(-eye_k[EYE_W-1:0]) : eye_k[EYE_W-1:0];
	assign bnd_w    = 50'(mul_q) <<< 16;
	assign diff_w   = bnd_w - 50'(eye_k);
	assign diff_mag = diff_w[49] ? FIX_W'(-diff_w) : diff_w[FIX_W-1:0];
	assign dir_mag  = dir_k[DIR_W-1] ? DEN_W'(-dir_k) : DEN_W'(dir_k);

	// Restoring divider, one quotient bit per cycle.
	assign trial    = {rem_q, numq_q[NUM_W-1]};
	assign ge       = (trial >= {1'b0, den_q});
	assign rem_n    = ge ? (trial - {1'b0, den_q}) : trial;
	assign q_fin    = {numq_q[NUM_W-2:0], ge};
	assign div_last = (cnt_q == CNT_W'(NUM_W - 1));

	always_comb begin
		logic signed [TILE_W-1:0] tq;
		tq      = {1'b0, q_fin[DEN_W-1:0]};
		t_res   = neg_q ? -tq : tq;
		q_sat   = (q_fin > QUO_LIM) ? FIX_MAX : $signed({1'b0, q_fin[FIX_W-2:0]});
		amt_res = neg_q ? -q_sat : q_sat;
	end

	// Shared multiplier: tile boundary, then the low and high halves of amt*dir.
	always_comb begin
		case (state_q)
			S_BND: begin
				mul_a = MA_W'(t_bnd);
				mul_b = $signed({8'd0, bs_eff});
			end
			S_MLO: begin
				mul_a = $signed({1'b0, amt_sel_q[23:0]});
				mul_b = dir_k;
			end
			default: begin
				mul_a = amt_sel_q[FIX_W-1:24];
				mul_b = dir_k;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Eye update with the small forward nudge, saturated.
	assign move_w  = $signed(acc_q[ACC_W-1:14]);
	assign move2_w = $signed(move_w[51:13]);
	assign eye_sum = SUM_W'(eye_k) + SUM_W'(move_w) + SUM_W'(move2_w);
	always_comb begin
		if (eye_sum > SUM_W'(FIX_MAX))
			eye_new = FIX_MAX;
		else if (eye_sum < SUM_W'(FIX_MIN))
			eye_new = FIX_MIN;
		else
			eye_new = eye_sum[FIX_W-1:0];
	end

	// Axis choice: strictly smallest distance wins, ties go to the higher axis, z before y before x.
	always_comb begin
		for (int i = 0; i < AXES; i++)
			nz[i] = (dir_q[i] != '0);
		ax0 = nz[0] && (!nz[1] || amt_q[0] < amt_q[1]) && (!nz[2] || amt_q[0] < amt_q[2]);
		ax1 = nz[1] && (!nz[2] || amt_q[1] < amt_q[2]);
		ax2 = nz[2];
		pick_none = !(ax0 || ax1 || ax2);
		ax_w = ax0 ? 2'd0 : (ax1 ? 2'd1 : 2'd2);
	end

	assign t_in_grid = !t_q[0][TILE_W-1] && !t_q[1][TILE_W-1] && !t_q[2][TILE_W-1] &&
		(t_q[0] < TILE_W'(GRID_W)) && (t_q[1] < TILE_W'(GRID_H)) && (t_q[2] < TILE_W'(GRID_D));
	assign raddr = AW'((32'(t_q[2][DEN_W-1:0]) * GRID_H + 32'(t_q[1][DEN_W-1:0])) * GRID_W
		+ 32'(t_q[0][DEN_W-1:0]));
	assign w_in_grid = (32'(cell_x) < GRID_W) && (32'(cell_y) < GRID_H) &&
		(32'(cell_z) < GRID_D);
	assign waddr = AW'((32'(cell_z) * GRID_H + 32'(cell_y)) * GRID_W + 32'(cell_x));

	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = OPEN_CODE_RST;
		end else begin
			mem_we = in_acc && (command == CMD_WRITE) && w_in_grid;
			mem_wa = waddr;
			mem_wd = cell_code;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (state_q == S_CHK)
			rd_q <= mem[raddr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= BLOCK_SIZE_RST;
			open_q <= OPEN_CODE_RST;
			lim_q  <= STEP_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLOCK_SIZE: bs_q   <= cfg_data;
				REG_OPEN_CODE:  open_q <= cfg_data;
				REG_STEP_LIMIT: lim_q  <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			tile_ph_q   <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In S_DONE a result leaving this cycle is replaced by the new one below.
			if (out_valid_q && out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc && command == CMD_QUERY) begin
						state_q <= S_TLOAD;
						k_q     <= '0;
						step_q  <= '0;
						hit_q   <= 1'b0;
					end
				end
				S_TLOAD: begin
					state_q   <= S_DIV;
					tile_ph_q <= 1'b1;
					cnt_q     <= '0;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (div_last) begin
						if (k_q == 2'(AXES - 1)) begin
							k_q     <= '0;
							state_q <= tile_ph_q ? S_STEP : S_PICK;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= tile_ph_q ? S_TLOAD : S_BND;
						end
					end
				end
				S_STEP: begin
					k_q     <= '0;
					state_q <= (step_q == lim_q) ? S_DONE : S_BND;
				end
				S_BND: begin
					if (dir_k == '0) begin
						if (k_q == 2'(AXES - 1)) begin
							k_q     <= '0;
							state_q <= S_PICK;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end else begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					state_q   <= S_DIV;
					tile_ph_q <= 1'b0;
					cnt_q     <= '0;
				end
				S_PICK: begin
					k_q     <= '0;
					state_q <= pick_none ? S_DONE : S_MLO;
				end
				S_MLO: state_q <= S_MHI;
				S_MHI: state_q <= S_SUM;
				S_SUM: state_q <= S_EYE;
				S_EYE: begin
					if (k_q == 2'(AXES - 1)) begin
						k_q     <= '0;
						state_q <= S_CHK;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_MLO;
					end
				end
				S_CHK: state_q <= t_in_grid ? S_CMP : S_DONE;
				S_CMP: begin
					if (rd_q != open_q) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						step_q  <= step_q + LIM_W'(1);
						state_q <= S_STEP;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && command == CMD_QUERY) begin
					eye_q[0] <= FIX_W'(eye_x);
					eye_q[1] <= FIX_W'(eye_y);
					eye_q[2] <= FIX_W'(eye_z);
					dir_q[0] <= dir_x;
					dir_q[1] <= dir_y;
					dir_q[2] <= dir_z;
				end
			end
			S_TLOAD: begin
				rem_q  <= '0;
				numq_q <= NUM_W'(eye_mag[EYE_W-1:16]);
				den_q  <= DEN_W'(bs_eff);
				neg_q  <= eye_k[FIX_W-1];
			end
			S_DIV: begin
				rem_q  <= rem_n[DEN_W-1:0];
				numq_q <= q_fin;
				if (div_last) begin
					if (tile_ph_q)
						t_q[k_q] <= t_res;
					else
						amt_q[k_q] <= amt_res;
				end
			end
			S_BND: mul_q <= mul_p;
			S_DIFF: begin
				rem_q  <= '0;
				numq_q <= {diff_mag, 14'd0};
				den_q  <= dir_mag;
				neg_q  <= diff_w[49] ^ dir_k[DIR_W-1];
			end
			S_PICK: begin
				for (int i = 0; i < AXES; i++)
					bef_q[i] <= t_q[i];
				if (!pick_none) begin
					t_q[ax_w] <= t_q[ax_w] + ((dir_q[ax_w] > 0) ? TILE_W'(1) : -TILE_W'(1));
					amt_sel_q <= amt_q[ax_w];
				end
			end
			S_MLO: mul_q <= mul_p;
			S_MHI: begin
				acc_q <= ACC_W'(mul_q);
				mul_q <= mul_p;
			end
			S_SUM: acc_q <= acc_q + (ACC_W'(mul_q) <<< 24);
			S_EYE: eye_q[k_q] <= eye_new;
			S_DONE: begin
				if (slot_free) begin
					hit_o_q <= hit_q;
					for (int i = 0; i < AXES; i++) begin
						pos_q[i]        <= hit_q ? t_q[i][POS_W-1:0] : POS_MISS;
						pos_q[AXES + i] <= hit_q ? bef_q[i][POS_W-1:0] : POS_MISS;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_o_q;
	assign hit_x     = pos_q[0];
	assign hit_y     = pos_q[1];
	assign hit_z     = pos_q[2];
	assign before_x  = pos_q[3];
	assign before_y  = pos_q[4];
	assign before_z  = pos_q[5];

endmodule

[rtl/core/vrp_check.sv]
// Port-level checker for the voxel ray picking block, bound to its top level.
module vrp_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              command,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              hit,
	input logic signed [vrp_pkg::POS_W-1:0]  hit_x,
	input logic signed [vrp_pkg::POS_W-1:0]  hit_y,
	input logic signed [vrp_pkg::POS_W-1:0]  hit_z,
	input logic signed [vrp_pkg::POS_W-1:0]  before_x,
	input logic signed [vrp_pkg::POS_W-1:0]  before_y,
	input logic signed [vrp_pkg::POS_W-1:0]  before_z
);
	import vrp_pkg::*;

	// A waiting result item keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_x) &&
		$stable(hit_y) && $stable(hit_z) && $stable(before_x) && $stable(before_y) &&
		$stable(before_z))
		else $error("result item changed while stalled");

	// A miss reports all coordinates as minus one.
	a_miss_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_x == POS_MISS && hit_y == POS_MISS && hit_z == POS_MISS &&
		before_x == POS_MISS && before_y == POS_MISS && before_z == POS_MISS)
		else $error("miss result with coordinates set");

	// The hit tile is one crossing away from the tile before it.
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> $countones({hit_x != before_x, hit_y != before_y,
		hit_z != before_z}) == 1)
		else $error("hit tile differs from previous tile on other than one axis");

	// A query keeps the input side busy while it walks the ray.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_QUERY |=> !in_ready)
		else $error("input ready right after a query item");

endmodule

bind voxel_ray_pick vrp_check u_vrp_check (.*);
